// ===== rtl/u8c_pkg.sv =====
`timescale 1ns / 1ps

package u8c_pkg;

  // most result bytes one input byte can cause (a surrogate pair)
  localparam int MAX_RESULTS = 6;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // byte constants of the surrogate encoding
  localparam logic [7:0]  SURR_LEAD    = 8'hED;
  localparam logic [7:0]  SURR_HI_BASE = 8'hA0;
  localparam logic [7:0]  SURR_LO_BASE = 8'hB0;
  localparam logic [7:0]  CONT_BASE    = 8'h80;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // one job: the output bytes caused by one accepted input byte
  typedef struct packed {
    logic [RES_CNT_W-1:0]        count;
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [MAX_RESULTS-1:0]      bad;
  } job_t;

endpackage

// ===== rtl/u8c_front.sv =====
`timescale 1ns / 1ps

module u8c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // in_byte [7:0]
  output logic              job_valid,
  input  logic              job_ready,
  output u8c_pkg::job_t     job
);

  logic [1:0]  pending_count;
  logic [1:0]  pending_count_next;
  logic [23:0] collected_bytes;
  logic [23:0] collected_bytes_next;

  logic        accept;
  logic        is_cont;
  logic        is_lead4;
  logic        do_collect;
  logic        do_pair;
  logic [20:0] code_point;
  logic [20:0] offset;
  logic [9:0]  hi;
  logic [9:0]  lo;

  // classify the incoming byte
  assign is_cont    = (s_tdata[7:6] == 2'b10);
  assign is_lead4   = (s_tdata[7:3] == 5'b11110);
  assign do_collect = (pending_count != 2'd0) && (pending_count != 2'd3) && is_cont;
  assign do_pair    = (pending_count == 2'd3) && is_cont;

  // an input byte is taken only while the queue has room
  assign s_tready  = job_ready;
  assign accept    = s_tvalid && s_tready;
  assign job_valid = accept && (job.count != '0);

  // surrogate split of the collected four-byte sequence
  assign code_point = {collected_bytes[18:16], collected_bytes[13:8],
                       collected_bytes[5:0], s_tdata[5:0]};
  assign offset     = code_point - u8c_pkg::SUPP_BASE;
  assign hi         = offset[19:10];
  assign lo         = offset[9:0];

  // build the job for this byte
  always_comb begin
    job       = '0;
    if (do_collect) begin
      job.count = '0;
    end else if (do_pair) begin
      job.count    = u8c_pkg::RES_CNT_W'(u8c_pkg::MAX_RESULTS);
      job.bytes[0] = u8c_pkg::SURR_LEAD;
      job.bytes[1] = u8c_pkg::SURR_HI_BASE | {4'b0, hi[9:6]};
      job.bytes[2] = u8c_pkg::CONT_BASE | {2'b0, hi[5:0]};
      job.bytes[3] = u8c_pkg::SURR_LEAD;
      job.bytes[4] = u8c_pkg::SURR_LO_BASE | {4'b0, lo[9:6]};
      job.bytes[5] = u8c_pkg::CONT_BASE | {2'b0, lo[5:0]};
    end else begin
      // flush an interrupted sequence, oldest byte first
      unique case (pending_count)
        2'd1: begin
          job.bytes[0] = collected_bytes[7:0];
          job.bad[0]   = 1'b1;
        end
        2'd2: begin
          job.bytes[0] = collected_bytes[15:8];
          job.bytes[1] = collected_bytes[7:0];
          job.bad[1:0] = 2'b11;
        end
        2'd3: begin
          job.bytes[0] = collected_bytes[23:16];
          job.bytes[1] = collected_bytes[15:8];
          job.bytes[2] = collected_bytes[7:0];
          job.bad[2:0] = 3'b111;
        end
        default: begin
        end
      endcase
      // a lead byte starts a new collection and gives nothing of its own
      job.bytes[{1'b0, pending_count}] = is_lead4 ? 8'h00 : s_tdata;
      job.count = u8c_pkg::RES_CNT_W'(pending_count) + u8c_pkg::RES_CNT_W'(!is_lead4);
    end
  end

  // collection state update
  always_comb begin
    pending_count_next   = pending_count;
    collected_bytes_next = collected_bytes;
    if (accept) begin
      if (do_collect) begin
        pending_count_next   = pending_count + 2'd1;
        collected_bytes_next = {collected_bytes[15:0], s_tdata};
      end else if (!do_pair && is_lead4) begin
        pending_count_next   = 2'd1;
        collected_bytes_next = {16'h0, s_tdata};
      end else begin
        pending_count_next   = 2'd0;
        collected_bytes_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count   <= 2'd0;
      collected_bytes <= '0;
    end else begin
      pending_count   <= pending_count_next;
      collected_bytes <= collected_bytes_next;
    end
  end

endmodule

// ===== rtl/u8c_queue.sv =====
`timescale 1ns / 1ps

module u8c_queue #(
  parameter int Depth = u8c_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  u8c_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output u8c_pkg::job_t out_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  u8c_pkg::job_t       entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     fill;
  logic                push;
  logic                pop;

  assign in_ready  = (fill != CntW'(Depth));
  assign out_valid = (fill != '0);
  assign out_job   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/u8c_back.sv =====
`timescale 1ns / 1ps

module u8c_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  u8c_pkg::job_t job,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // out_byte [7:0]
  output logic          m_tlast,   // last_of_run
  output logic [0:0]    m_tuser    // bad_sequence [0]
);

  u8c_pkg::job_t                  cur;
  logic                           busy;
  logic [u8c_pkg::RES_IDX_W-1:0]  idx;
  logic [u8c_pkg::RES_IDX_W-1:0]  idx_next;
  logic                           busy_next;
  logic                           xfer;
  logic                           done;
  logic                           load;

  // present the current byte of the held job
  assign m_tvalid = busy;
  assign m_tdata  = cur.bytes[idx];
  assign m_tuser  = cur.bad[idx];
  assign m_tlast  = (u8c_pkg::RES_CNT_W'(idx) == cur.count - u8c_pkg::RES_CNT_W'(1));

  assign xfer      = m_tvalid && m_tready;
  assign done      = xfer && m_tlast;
  assign load      = (!busy || done) && job_valid;
  assign job_ready = !busy || done;

  // step through the job one byte per transfer
  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    if (load) begin
      busy_next = 1'b1;
      idx_next  = '0;
    end else if (done) begin
      busy_next = 1'b0;
      idx_next  = '0;
    end else if (xfer) begin
      idx_next  = idx + u8c_pkg::RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  // job holding register
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end
  end

endmodule

// ===== rtl/utf8_to_cesu8_converter.sv =====
`timescale 1ns / 1ps

// UTF-8 to CESU-8 converter. Takes one UTF-8 byte per transfer on the s_ side and
// gives CESU-8 bytes on the m_ side, one byte per transfer; m_tlast marks the last
// output byte caused by an input byte and m_tuser flags bytes flushed from an
// interrupted four-byte sequence. An input byte is taken in any cycle in which the
// job queue has room, so the input runs at one byte per cycle until the output side
// falls behind. The output side emits one byte per cycle while m_tready is high:
// most input bytes give one output byte, a completed four-byte character gives six
// (a surrogate pair) and the first three bytes of it give none, so for a stream of
// such characters the back end's single output byte per cycle limits the input
// rate. Each job is held in a queue entry, then in the back end's job register.
module utf8_to_cesu8_converter #(
  parameter int QueueDepth = u8c_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte [7:0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte [7:0]
  output logic       m_tlast,   // last_of_run
  output logic [0:0] m_tuser    // bad_sequence [0]
);

  u8c_pkg::job_t front_job;
  logic          front_valid;
  logic          front_ready;
  u8c_pkg::job_t back_job;
  logic          back_valid;
  logic          back_ready;

  // classify and collect
  u8c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // decoupling queue
  u8c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_job    (front_job),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_job   (back_job)
  );

  // serialize jobs into output bytes
  u8c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== rtl/u8c_checker.sv =====
`timescale 1ns / 1ps

module u8c_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [0:0] m_tuser
);

  // a stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // flushed bytes are only four-byte leads or continuation bytes
  a_bad_bytes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[7:6] == 2'b10) || (m_tdata[7:3] == 5'b11110))
    else $error("flagged byte is not part of a four-byte sequence");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input backpressure only while the output side holds work
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with output side idle");

endmodule

bind utf8_to_cesu8_converter u8c_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off for the pressure test
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 20;    // quiet time after the last expected byte

  // one expected output byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } cesu8_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [0:0] m_tuser;

  // predictor state: bytes of a four-byte character gathered so far
  logic [1:0]  seq_count = 2'd0;
  logic [23:0] seq_bytes = 24'h0;

  cesu8_byte_t cesu8_expected[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bit          rx_hold_req = 1'b0;
  int          rx_hold_left = 0;

  utf8_to_cesu8_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // push one expected byte
  task automatic expect_byte(input logic [7:0] data, input logic last, input logic bad);
    cesu8_byte_t item;
    item.data = data;
    item.last = last;
    item.bad  = bad;
    cesu8_expected.push_back(item);
  endtask

  // work out the output bytes caused by one accepted input byte
  task automatic predict_cesu8(input logic [7:0] b);
    logic [20:0] code_point;
    logic [20:0] offset;
    logic [9:0]  hi;
    logic [9:0]  lo;
    int          pending;
    int          k;
    int          first;
    first   = cesu8_expected.size();
    pending = int'(seq_count);
    if (pending != 0 && b[7:6] == 2'b10) begin
      if (pending < 3) begin
        // still gathering the character
        seq_bytes = {seq_bytes[15:0], b};
        seq_count = seq_count + 2'd1;
      end else begin
        // fourth byte: split into a surrogate pair
        code_point = {seq_bytes[18:16], seq_bytes[13:8], seq_bytes[5:0], b[5:0]};
        offset     = code_point - u8c_pkg::SUPP_BASE;
        hi         = offset[19:10];
        lo         = offset[9:0];
        expect_byte(u8c_pkg::SURR_LEAD, 1'b0, 1'b0);
        expect_byte(u8c_pkg::SURR_HI_BASE + {4'h0, hi[9:6]}, 1'b0, 1'b0);
        expect_byte(u8c_pkg::CONT_BASE + {2'b00, hi[5:0]}, 1'b0, 1'b0);
        expect_byte(u8c_pkg::SURR_LEAD, 1'b0, 1'b0);
        expect_byte(u8c_pkg::SURR_LO_BASE + {4'h0, lo[9:6]}, 1'b0, 1'b0);
        expect_byte(u8c_pkg::CONT_BASE + {2'b00, lo[5:0]}, 1'b1, 1'b0);
        seq_count = 2'd0;
        seq_bytes = 24'h0;
      end
    end else begin
      // flush an interrupted character, oldest byte first
      for (k = pending - 1; k >= 0; k--) begin
        expect_byte(seq_bytes[8*k +: 8], 1'b0, 1'b1);
      end
      seq_count = 2'd0;
      seq_bytes = 24'h0;
      if (b[7:3] == 5'b11110) begin
        // new four-byte lead: no byte of its own
        seq_count = 2'd1;
        seq_bytes = {16'h0, b};
        if (cesu8_expected.size() > first) begin
          cesu8_expected[cesu8_expected.size() - 1].last = 1'b1;
        end
      end else begin
        expect_byte(b, 1'b1, 1'b0);
      end
    end
  endtask

  // offer one byte on the input side until it is taken
  task automatic send_utf8_byte(input logic [7:0] b);
    @(negedge clk);
    while (tx_gaps_on && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predict_cesu8(b);
    bytes_sent++;
  endtask

  task automatic send_cont_byte;
    logic [7:0] r;
    r = 8'($urandom);
    send_utf8_byte({2'b10, r[5:0]});
  endtask

  // one random character: mostly well formed, some broken and some noise
  task automatic send_random_char;
    logic [7:0] r;
    int         kind;
    int         n;
    r    = 8'($urandom);
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      send_utf8_byte({1'b0, r[6:0]});
    end else if (kind < 6) begin
      send_utf8_byte({3'b110, r[4:0]});
      send_cont_byte();
    end else if (kind < 9) begin
      send_utf8_byte({4'b1110, r[3:0]});
      repeat (2) send_cont_byte();
    end else if (kind < 15) begin
      send_utf8_byte({5'b11110, r[2:0]});
      repeat (3) send_cont_byte();
    end else if (kind < 17) begin
      // four-byte character cut short
      n = $urandom_range(0, 2);
      send_utf8_byte({5'b11110, r[2:0]});
      repeat (n) send_cont_byte();
    end else begin
      send_utf8_byte(r);
    end
  endtask

  // bytes that pass through as single results
  task automatic test_passthrough;
    send_utf8_byte(8'h00);
    send_utf8_byte(8'h7F);
    send_utf8_byte(8'h80);
    send_utf8_byte(8'hC3);
    send_utf8_byte(8'hF8);
    send_utf8_byte(8'hFF);
  endtask

  // four-byte characters, lowest one, overlong and above the last code point
  task automatic test_supplementary;
    send_utf8_byte(8'hF0); send_utf8_byte(8'h90); send_utf8_byte(8'h80); send_utf8_byte(8'h80);
    send_utf8_byte(8'hF7); send_utf8_byte(8'hBF); send_utf8_byte(8'hBF); send_utf8_byte(8'hBF);
    send_utf8_byte(8'hF0); send_utf8_byte(8'h80); send_utf8_byte(8'h80); send_utf8_byte(8'h80);
  endtask

  // interrupted characters: plain byte after a lead, new lead after two bytes, plain byte after three
  task automatic test_interrupted;
    send_utf8_byte(8'hF0); send_utf8_byte(8'h41);
    send_utf8_byte(8'hF1); send_utf8_byte(8'h80); send_utf8_byte(8'hF2);
    send_utf8_byte(8'h80); send_utf8_byte(8'hBF); send_utf8_byte(8'hC0);
  endtask

  // random stream with idling on both sides
  task automatic test_random_mix;
    int stop_at;
    stop_at = bytes_sent + 150;
    while (bytes_sent < stop_at) send_random_char();
  endtask

  // random stream with no idling at all
  task automatic test_full_rate;
    int stop_at;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    stop_at = bytes_sent + 60;
    while (bytes_sent < stop_at) send_random_char();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure;
    int stop_at;
    rx_hold_req = 1'b1;
    tx_gaps_on  = 1'b0;
    stop_at = bytes_sent + 40;
    while (bytes_sent < stop_at) send_random_char();
    tx_gaps_on = 1'b1;
  endtask

  // receiver side: random stalls and the long hold-off
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 8) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // check every output transfer and watch for a hang
  always @(posedge clk) begin
    cesu8_byte_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (m_tvalid && m_tready) begin
        if (cesu8_expected.size() == 0) begin
          $error("unexpected output byte %h", m_tdata);
          errors++;
        end else begin
          want = cesu8_expected.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, m_tlast);
            errors++;
          end
          if (m_tuser[0] !== want.bad) begin
            $error("bad_sequence: expected %b, got %b", want.bad, m_tuser[0]);
            errors++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("utf8_to_cesu8_converter: mismatch");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_supplementary();
    test_interrupted();
    test_random_mix();
    test_full_rate();
    test_backpressure();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cesu8_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_to_cesu8_converter: match");
    end else begin
      $display("utf8_to_cesu8_converter: mismatch");
    end
    $finish;
  end

endmodule
